### rtl/lzw_compress_z_decoder_unit_defines.svh
// assertion macros for the lzw decoder unit
// no dependencies
`ifndef LZW_COMPRESS_Z_DECODER_UNIT_DEFINES_SVH
`define LZW_COMPRESS_Z_DECODER_UNIT_DEFINES_SVH
// implication checked on every rising edge outside reset
`define LZD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzd check failed");
// next-cycle implication checked on every rising edge outside reset
`define LZD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzd check failed");
`endif

### rtl/lzd_pkg.sv
// types and constants of the lzw decoder unit
// no dependencies
`default_nettype none
package lzd_pkg;
  localparam int unsigned StartWidth = 9;
  localparam logic [8:0] ClearCode = 9'd256;
  localparam logic [8:0] FirstFree = 9'd257;

  localparam logic [2:0] StFed = 3'd0;
  localparam logic [2:0] StBusy = 3'd1;
  localparam logic [2:0] StData = 3'd2;
  localparam logic [2:0] StEmpty = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  localparam logic CmdFeed = 1'b0;
  localparam logic CmdPull = 1'b1;

  localparam logic RegMaxBits = 1'b0;
  localparam logic RegBlockMode = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CHAIN,
    S_FINISH,
    S_POP,
    S_RESULT
  } state_e;
endpackage
`default_nettype wire

### rtl/lzd_ram.sv
// generic simple dual-port synchronous ram (one write port, one read port) with registered read
// no dependencies
`default_nettype none
module lzd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/lzw_compress_z_decoder_unit.sv
// lzw (.Z) decoder: bit unpacking, dictionary and output stack
// depends on lzd_pkg, lzd_ram and lzw_compress_z_decoder_unit_defines.svh
//
//  channel  direction  handshake           payload
//  in       to block   in_valid_i/stall_o  cmd_i in_byte_i in_last_i
//  out      from block out_valid_o/stall_i status_o out_byte_o out_final_o
//                                          checksum_o bytes_out_o
//  cfg      to block   cfg_we_i            cfg_idx_i cfg_data_i
//
// pull, refused feed, first or clear code: decode, pop if data, result
// other feed that completes a code: decode, chain, finish, result, with
// one dictionary read per cycle from the table memory in chain
// after reset a clearing pass writes every suffix table entry
// the result register holds while out_stall_i is high; no input is taken then
`default_nettype none
`include "lzw_compress_z_decoder_unit_defines.svh"
module lzw_compress_z_decoder_unit #(
  parameter int unsigned MaxCodeBits = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  status_o,
  output      logic [7:0]  out_byte_o,
  output      logic        out_final_o,
  output      logic [15:0] checksum_o,
  output      logic [31:0] bytes_out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [4:0]  cfg_data_i
);
  import lzd_pkg::*;

  localparam int unsigned AW = MaxCodeBits;
  localparam int unsigned Depth = 1 << MaxCodeBits;
  localparam int unsigned LW = MaxCodeBits + 1;
  localparam int unsigned CW = $clog2(MaxCodeBits + 1);

  state_e state_q, state_d;

  logic [4:0]  max_bits_q;
  logic        block_mode_q;
  logic [LW-1:0] level_q, level_d;
  logic [23:0] acc_q, acc_d;
  logic [4:0]  fill_q, fill_d;
  logic [4:0]  gpos_q, gpos_d;
  logic [4:0]  skip_q, skip_d;
  logic [CW-1:0] cw_q, cw_d;
  logic [LW-1:0] wlim_q, wlim_d;
  logic [LW-1:0] nfree_q, nfree_d;
  logic [AW-1:0] pcode_q, pcode_d;
  logic [7:0]  pchar_q, pchar_d;
  logic        first_q, first_d;
  logic        ended_q, ended_d;
  logic [15:0] sum_q, sum_d;
  logic [31:0] cnt_q, cnt_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] incode_q, incode_d;
  logic        clrp_q, clrp_d;
  logic [AW-1:0] init_q;
  logic        cmd_q, last_q;
  logic [7:0]  byte_q;
  logic [2:0]  st_q, st_d;
  logic [7:0]  ob_q, ob_d;
  logic        of_q, of_d;
  logic        ov_q, ov_d;

  logic          pre_we, suf_we, stk_we;
  logic [AW-1:0] pre_wa, suf_wa, stk_wa, pre_ra, suf_ra, stk_ra;
  logic [AW-1:0] pre_wd, pre_rd;
  logic [7:0]    suf_wd, suf_rd, stk_wd, stk_rd;

  lzd_ram #(.Width(AW), .Depth(Depth)) u_prefix (
    .clk_i, .we_i(pre_we), .waddr_i(pre_wa), .wdata_i(pre_wd),
    .raddr_i(pre_ra), .rdata_o(pre_rd));
  lzd_ram #(.Width(8), .Depth(Depth)) u_suffix (
    .clk_i, .we_i(suf_we), .waddr_i(suf_wa), .wdata_i(suf_wd),
    .raddr_i(suf_ra), .rdata_o(suf_rd));
  lzd_ram #(.Width(8), .Depth(Depth)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));

  logic [4:0] emax;
  always_comb begin
    emax = max_bits_q;
    if (emax < 5'(StartWidth)) emax = 5'(StartWidth);
    if (emax > 5'(MaxCodeBits)) emax = 5'(MaxCodeBits);
  end

  // bit unpacking of one fed byte
  logic [23:0] acc_new;
  logic [4:0]  fill_new, gpos_inc;
  logic        has_code;
  logic [AW-1:0] code_w;
  always_comb begin
    acc_new  = acc_q | (24'(byte_q) << fill_q);
    fill_new = fill_q + 5'd8;
    gpos_inc = gpos_q + 5'd1;
    has_code = fill_new >= 5'(cw_q);
    code_w   = AW'(acc_new & ((24'd1 << cw_q) - 24'd1));
  end

  assign in_stall_o  = (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign status_o    = st_q;
  assign out_byte_o  = ob_q;
  assign out_final_o = of_q;
  assign checksum_o  = sum_q;
  assign bytes_out_o = cnt_q;

  logic full_stack;
  assign full_stack = level_q >= LW'(Depth - 1);

  logic take;
  assign take = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:   if (init_q == AW'(Depth - 1)) state_d = S_IDLE;
      S_IDLE:   if (take) state_d = S_DECODE;
      S_DECODE: begin
        if (cmd_q == CmdPull || level_q != '0 || ended_q || skip_q != '0 || !has_code ||
            !first_q || (block_mode_q && code_w == AW'(ClearCode))) begin
          state_d = (cmd_q == CmdPull && level_q != '0) ? S_POP : S_RESULT;
        end else begin
          state_d = S_CHAIN;
        end
      end
      S_CHAIN:  if (cur_q < AW'(256) || full_stack) state_d = S_FINISH;
      S_FINISH: state_d = S_RESULT;
      S_POP:    state_d = S_RESULT;
      S_RESULT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    level_d = level_q; acc_d = acc_q; fill_d = fill_q; gpos_d = gpos_q;
    skip_d = skip_q; cw_d = cw_q; wlim_d = wlim_q; nfree_d = nfree_q;
    pcode_d = pcode_q; pchar_d = pchar_q; first_d = first_q; ended_d = ended_q;
    sum_d = sum_q; cnt_d = cnt_q; cur_d = cur_q; incode_d = incode_q;
    clrp_d = clrp_q; st_d = st_q; ob_d = ob_q; of_d = of_q; ov_d = ov_q;
    pre_we = 1'b0; pre_wa = nfree_q[AW-1:0]; pre_wd = pcode_q;
    suf_we = 1'b0; suf_wa = nfree_q[AW-1:0]; suf_wd = suf_rd;
    stk_we = 1'b0; stk_wa = level_q[AW-1:0]; stk_wd = suf_rd;
    pre_ra = cur_q; suf_ra = cur_q;
    stk_ra = level_q[AW-1:0] - AW'(1);
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_INIT: begin
        suf_we = 1'b1; suf_wa = init_q;
        suf_wd = (init_q < AW'(256)) ? init_q[7:0] : 8'd0;
      end
      S_IDLE: ;
      S_DECODE: begin
        st_d = StFed; ob_d = '0; of_d = 1'b0;
        if (cmd_q == CmdPull) begin
          if (level_q == '0) st_d = ended_q ? StDone : StEmpty;
        end else if (level_q != '0) begin
          st_d = StBusy;
        end else if (ended_q) begin
          st_d = StDone;
        end else begin
          if (last_q) ended_d = 1'b1;
          if (skip_q != '0) begin
            skip_d = skip_q - 5'd1;
          end else if (!has_code) begin
            acc_d = acc_new; fill_d = fill_new;
            gpos_d = (gpos_inc >= 5'(cw_q)) ? 5'd0 : gpos_inc;
          end else begin
            acc_d = acc_new >> cw_q; fill_d = fill_new - 5'(cw_q);
            gpos_d = gpos_inc;
            incode_d = code_w;
            if (!first_q) begin
              first_d = 1'b1;
              nfree_d = block_mode_q ? LW'(FirstFree) : LW'(ClearCode);
              pcode_d = code_w; pchar_d = code_w[7:0];
              stk_we = 1'b1; stk_wa = '0; stk_wd = code_w[7:0];
              level_d = LW'(1);
            end else if (block_mode_q && code_w == AW'(ClearCode)) begin
              nfree_d = LW'(ClearCode); clrp_d = 1'b1;
            end else if (LW'(code_w) >= nfree_q) begin
              stk_we = 1'b1; stk_wa = '0; stk_wd = pchar_q;
              level_d = LW'(1); cur_d = pcode_q;
            end else begin
              cur_d = code_w;
            end
            pre_ra = cur_d; suf_ra = cur_d;
          end
        end
      end
      S_CHAIN: begin
        if (cur_q < AW'(256) || full_stack) begin
          pchar_d = suf_rd;
          stk_we = 1'b1; stk_wd = suf_rd;
          level_d = level_q + LW'(1);
        end else begin
          stk_we = 1'b1; stk_wd = suf_rd;
          level_d = level_q + LW'(1);
          cur_d = pre_rd;
          pre_ra = pre_rd; suf_ra = pre_rd;
        end
      end
      S_FINISH: begin
        if (nfree_q < (LW'(1) << emax)) begin
          pre_we = 1'b1; suf_we = 1'b1; suf_wd = pchar_q;
          nfree_d = nfree_q + LW'(1);
        end
        pcode_d = incode_q;
      end
      S_POP: begin
        level_d = level_q - LW'(1);
        ob_d = stk_rd;
        sum_d = {sum_q[0], sum_q[15:1]} + 16'(stk_rd);
        cnt_d = cnt_q + 32'd1;
        of_d = (level_d == '0) && ended_q;
        st_d = StData;
      end
      S_RESULT: begin
        ov_d = 1'b1;
        if (st_q == StFed && (clrp_q || nfree_q > wlim_q) && fill_q != 5'd0 ||
            st_q == StFed && (clrp_q || nfree_q > wlim_q) && acc_q == '0) begin
          if (gpos_q >= 5'(cw_q)) gpos_d = 5'd0;
        end
        if (st_q == StFed) begin
          if (gpos_q >= 5'(cw_q)) gpos_d = 5'd0;
          if (clrp_q || nfree_q > wlim_q) begin
            skip_d = (gpos_q >= 5'(cw_q) || gpos_q == 5'd0) ? 5'd0 : 5'(cw_q) - gpos_q;
            gpos_d = 5'd0; acc_d = '0; fill_d = '0;
            if (nfree_q > wlim_q) begin
              if (cw_q < CW'(MaxCodeBits)) cw_d = cw_q + CW'(1);
              if (5'(cw_d) == emax || cw_d == CW'(MaxCodeBits))
                wlim_d = LW'(1) << cw_d;
              else
                wlim_d = (LW'(1) << cw_d) - LW'(1);
            end
            if (clrp_q) begin
              cw_d = CW'(StartWidth);
              wlim_d = LW'((1 << StartWidth) - 1);
              clrp_d = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; init_q <= '0;
      max_bits_q <= 5'd16; block_mode_q <= 1'b1;
      level_q <= '0; acc_q <= '0; fill_q <= '0; gpos_q <= '0; skip_q <= '0;
      cw_q <= CW'(StartWidth); wlim_q <= LW'((1 << StartWidth) - 1);
      nfree_q <= LW'(FirstFree); pcode_q <= '0; pchar_q <= '0;
      first_q <= 1'b0; ended_q <= 1'b0; sum_q <= '0; cnt_q <= '0;
      clrp_q <= 1'b0; ov_q <= 1'b0; st_q <= StFed;
    end else begin
      state_q <= state_d;
      if (state_q == S_INIT) init_q <= init_q + AW'(1);
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMaxBits) max_bits_q <= cfg_data_i;
        else block_mode_q <= cfg_data_i[0];
      end
      level_q <= level_d; acc_q <= acc_d; fill_q <= fill_d; gpos_q <= gpos_d;
      skip_q <= skip_d; cw_q <= cw_d; wlim_q <= wlim_d; nfree_q <= nfree_d;
      pcode_q <= pcode_d; pchar_q <= pchar_d; first_q <= first_d;
      ended_q <= ended_d; sum_q <= sum_d; cnt_q <= cnt_d; clrp_q <= clrp_d;
      ov_q <= ov_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; incode_q <= incode_d; ob_q <= ob_d; of_q <= of_d;
    if (take) begin
      cmd_q <= cmd_i; byte_q <= in_byte_i; last_q <= in_last_i;
    end
  end

  `LZD_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, state_q != S_IDLE, in_stall_o)
  `LZD_ASSERT_NXT(a_pop_dec, clk_i, rst_ni, state_q == S_POP, level_q == $past(level_q) - LW'(1))
  `LZD_ASSERT_IMP(a_width_cap, clk_i, rst_ni, 1'b1, cw_q <= CW'(MaxCodeBits))
endmodule
`default_nettype wire

### dv/tb_lzw_compress_z_decoder_unit.sv
// testbench for the lzw (.Z) decoder unit: builds well-formed code streams,
// feeds and pulls through the valid/stall channels and checks every result
// depends on lzd_pkg and the decoder rtl
`timescale 1ns / 1ps
module tb_lzw_compress_z_decoder_unit;
  import lzd_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TblSize = 65536;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data;
    logic        fin;
    logic [15:0] sum;
    logic [31:0] cnt;
  } dec_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        cmd_r = CmdFeed;
  logic [7:0]  byte_r = 8'h00;
  logic        last_r = 1'b0;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = RegMaxBits;
  logic [4:0]  cfg_data = 5'd0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        out_final;
  logic [15:0] checksum;
  logic [31:0] bytes_out;

  lzw_compress_z_decoder_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd_r),
    .in_byte_i   (byte_r),
    .in_last_i   (last_r),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .out_byte_o  (out_byte),
    .out_final_o (out_final),
    .checksum_o  (checksum),
    .bytes_out_o (bytes_out),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  dec_rsp_t    answer_q[$];
  dec_rsp_t    got_rsp;
  dec_rsp_t    want_rsp;
  bit          in_take;
  bit          out_take;
  int unsigned mismatch_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned item_cnt = 0;
  int          rx_gap = 0;
  bit          hold_on = 0;
  bit          no_idle = 0;
  bit          allow_clear = 1;
  bit          refuse_all = 0;

  // decoder shadow
  logic [4:0]  cfg_max = 5'd16;
  logic        cfg_blk = 1'b1;
  logic [15:0] pfx_tbl [TblSize];
  logic [7:0]  sfx_tbl [TblSize];
  logic [7:0]  chr_stk [TblSize];
  int unsigned p_lvl, p_acc, p_fill, p_gpos, p_skip, p_w, p_lim, p_nf;
  int unsigned p_prev, p_pchar;
  bit          p_clr, p_first, p_end;
  logic [15:0] p_sum;
  logic [31:0] p_cnt;

  // stream builder state
  int          g_w = StartWidth;
  int          g_lim = 511;
  int          g_nf = 257;
  bit          g_first = 0;
  bit          g_prev_safe = 0;
  bit          g_safe [TblSize];
  longint      g_acc = 0;
  int          g_nbits = 0;
  int          g_ncodes = 0;
  int          g_nbytes = 0;

  function automatic int eff_bits();
    int m;
    m = cfg_max;
    if (m < StartWidth) m = StartWidth;
    if (m > 16) m = 16;
    return m;
  endfunction

  function automatic int grown_limit(int w);
    if (w == eff_bits() || w == 16) return 1 << w;
    return (1 << w) - 1;
  endfunction

  function automatic void push_char(int unsigned v);
    if (p_lvl < TblSize) begin
      chr_stk[p_lvl] = v[7:0];
      p_lvl++;
    end
  endfunction

  function automatic void expand_code(int unsigned c);
    int unsigned cur;
    if (!p_first) begin
      p_first = 1;
      p_nf = cfg_blk ? FirstFree : ClearCode;
      p_prev = c;
      p_pchar = c & 8'hff;
      push_char(p_pchar);
      return;
    end
    if (cfg_blk && c == ClearCode) begin
      p_nf = ClearCode;
      p_clr = 1;
      return;
    end
    cur = c;
    if (cur >= p_nf) begin
      push_char(p_pchar);
      cur = p_prev;
    end
    while (cur >= 256 && p_lvl < TblSize - 1) begin
      push_char(sfx_tbl[cur[15:0]]);
      cur = pfx_tbl[cur[15:0]];
    end
    p_pchar = sfx_tbl[cur[15:0]];
    push_char(p_pchar);
    if (p_nf < (1 << eff_bits())) begin
      pfx_tbl[p_nf[15:0]] = p_prev[15:0];
      sfx_tbl[p_nf[15:0]] = p_pchar[7:0];
      p_nf++;
    end
    p_prev = c & 16'hffff;
  endfunction

  function automatic void unpack_byte(logic [7:0] b);
    int unsigned c;
    if (p_skip > 0) begin
      p_skip--;
      return;
    end
    p_acc |= int'(b) << p_fill;
    p_fill += 8;
    p_gpos++;
    if (p_fill < p_w) begin
      if (p_gpos >= p_w) p_gpos = 0;
      return;
    end
    c = p_acc & ((1 << p_w) - 1);
    p_acc >>= p_w;
    p_fill -= p_w;
    expand_code(c);
    if (p_gpos >= p_w) p_gpos = 0;
    if (p_clr || p_nf > p_lim) begin
      p_skip = p_gpos ? p_w - p_gpos : 0;
      p_gpos = 0;
      p_acc = 0;
      p_fill = 0;
      if (p_nf > p_lim) begin
        if (p_w < 16) p_w++;
        p_lim = grown_limit(p_w);
      end
      if (p_clr) begin
        p_w = StartWidth;
        p_lim = 511;
        p_clr = 0;
      end
    end
  endfunction

  function automatic dec_rsp_t decode_predict(logic cmd, logic [7:0] b, logic last);
    dec_rsp_t r;
    r = '0;
    if (cmd == CmdFeed) begin
      if (p_lvl > 0) r.status = StBusy;
      else if (p_end) r.status = StDone;
      else begin
        unpack_byte(b);
        if (last) p_end = 1;
        r.status = StFed;
      end
    end else if (p_lvl > 0) begin
      p_lvl--;
      r.data = chr_stk[p_lvl[15:0]];
      p_sum = {p_sum[0], p_sum[15:1]} + {8'h00, r.data};
      p_cnt = p_cnt + 1;
      r.fin = (p_lvl == 0 && p_end);
      r.status = StData;
    end else begin
      r.status = p_end ? StDone : StEmpty;
    end
    r.sum = p_sum;
    r.cnt = p_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint act);
    if (want != act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, act);
      mismatch_cnt++;
    end
  endfunction

  always @(negedge clk) begin
    in_take = rst_n && in_valid && (in_stall === 1'b0);
    out_take = rst_n && (out_valid === 1'b1) && !out_stall;
    got_rsp = {status, out_byte, out_final, checksum, bytes_out};
  end

  always @(posedge clk) begin
    if (out_take) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with none expected, actual status %0d", $time, got_rsp.status);
        mismatch_cnt++;
      end else begin
        want_rsp = answer_q.pop_front();
        check_field("status", want_rsp.status, got_rsp.status);
        check_field("out_byte", want_rsp.data, got_rsp.data);
        check_field("out_final", want_rsp.fin, got_rsp.fin);
        check_field("checksum", want_rsp.sum, got_rsp.sum);
        check_field("bytes_out", want_rsp.cnt, got_rsp.cnt);
      end
    end
  end

  always @(posedge clk) begin
    if (out_take) rx_gap = no_idle ? 0 : $urandom_range(0, 10);
    else if (rx_gap > 0) rx_gap--;
    out_stall <= hold_on || rx_gap > 0;
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic do_item(logic cmd, logic [7:0] b, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_r <= cmd;
    byte_r <= b;
    last_r <= last;
    do @(posedge clk); while (!in_take);
    answer_q.push_back(decode_predict(cmd, b, last));
    item_cnt++;
  endtask

  task automatic drain_stack();
    if (p_lvl > 0 && (refuse_all || $urandom_range(0, 99) < 8))
      do_item(CmdFeed, 8'($urandom), 1'($urandom));
    while (p_lvl > 0) do_item(CmdPull, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) < 5) do_item(CmdPull, 8'($urandom), 1'($urandom));
  endtask

  task automatic feed_byte(logic [7:0] b, logic last);
    do_item(CmdFeed, b, last);
    drain_stack();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    if (idx == RegMaxBits) cfg_max = v;
    else cfg_blk = v[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // codes stay decodable: every chain read was written from known-good entries
  function automatic int pick_code();
    int top, r, c;
    top = 1 << g_w;
    r = $urandom_range(0, 99);
    if (cfg_blk && allow_clear && r < 2) return ClearCode;
    if (r < 12 && g_prev_safe && g_nf < top) return g_nf;
    if (r < 14 && g_prev_safe && g_nf + 1 < top) return $urandom_range(g_nf + 1, top - 1);
    if ($urandom_range(0, 99) < 60 || g_nf <= 257) return $urandom_range(0, 255);
    c = $urandom_range(256, g_nf - 1);
    if ((cfg_blk && c == ClearCode) || !g_safe[c]) c = $urandom_range(0, 255);
    return c;
  endfunction

  task automatic put_code(int c);
    bit brk;
    bit clr;
    bit ps;
    brk = 0;
    clr = 0;
    g_acc |= longint'(c) << g_nbits;
    g_nbits += g_w;
    g_ncodes++;
    if (!g_first) begin
      g_first = 1;
      g_nf = cfg_blk ? FirstFree : ClearCode;
      g_prev_safe = c < 256;
    end else if (cfg_blk && c == ClearCode) begin
      clr = 1;
      g_nf = ClearCode;
    end else begin
      ps = g_prev_safe;
      if (g_nf < (1 << eff_bits())) begin
        g_safe[g_nf] = ps;
        g_nf++;
      end
      g_prev_safe = (c < 256) || g_safe[c];
    end
    while (g_nbits >= 8) begin
      feed_byte(8'(g_acc), 1'b0);
      g_acc >>= 8;
      g_nbits -= 8;
      g_nbytes++;
    end
    brk = clr || g_nf > g_lim;
    if (brk) begin
      if (g_nbits > 0) begin
        feed_byte(8'(g_acc) | (8'($urandom) & (8'hff << g_nbits)), 1'b0);
        g_nbytes++;
      end
      repeat (g_w - g_nbytes) feed_byte(8'($urandom), 1'b0);
      if (g_nf > g_lim) begin
        if (g_w < 16) g_w++;
        g_lim = grown_limit(g_w);
      end
      if (clr) begin
        g_w = StartWidth;
        g_lim = 511;
      end
    end
    if (brk || g_ncodes == 8) begin
      g_acc = 0;
      g_nbits = 0;
      g_ncodes = 0;
      g_nbytes = 0;
    end
  endtask

  task automatic complete_group();
    while (g_ncodes != 0) put_code(pick_code());
    settle();
  endtask

  task automatic test_directed();
    cfg_write(RegMaxBits, 5'd16);
    cfg_write(RegBlockMode, 1'b1);
    refuse_all = 1;
    do_item(CmdPull, 8'hff, 1'b1);
    // literal from an out-of-range first code, kwkwk, then clear and refill
    put_code(300);
    put_code(65);
    put_code(66);
    put_code(258);
    put_code(260);
    put_code(ClearCode);
    put_code(97);
    put_code(98);
    put_code(255);
    put_code(0);
    refuse_all = 0;
    complete_group();
  endtask

  task automatic test_dict_full();
    allow_clear = 0;
    cfg_write(RegMaxBits, 5'd9);
    while (g_nf < 512) put_code(pick_code());
    repeat (16) put_code(pick_code());
    complete_group();
  endtask

  task automatic test_mode_switch();
    cfg_write(RegMaxBits, 5'd0);
    repeat (10) put_code(pick_code());
    complete_group();
    cfg_write(RegBlockMode, 1'b0);
    if (g_safe[ClearCode]) put_code(ClearCode);
    repeat (20) put_code(pick_code());
    complete_group();
    cfg_write(RegMaxBits, 5'd31);
    cfg_write(RegBlockMode, 1'b1);
    allow_clear = 1;
  endtask

  task automatic test_backpressure();
    hold_on = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_on = 0;
      end
    join_none
    repeat (30) put_code(pick_code());
    complete_group();
  endtask

  task automatic test_random();
    cfg_write(RegMaxBits, 5'd12);
    no_idle = 1;
    repeat (60) put_code(pick_code());
    no_idle = 0;
    while (item_cnt < 1500) put_code(pick_code());
    complete_group();
    cfg_write(RegMaxBits, 5'd16);
  endtask

  task automatic test_stream_end();
    repeat (5) put_code(pick_code());
    // leftover bits below one code are dropped by the decoder
    if (g_nbits > 0) feed_byte(8'(g_acc) | (8'($urandom) & (8'hff << g_nbits)), 1'b1);
    else feed_byte(8'($urandom), 1'b1);
    do_item(CmdFeed, 8'($urandom), 1'b0);
    do_item(CmdPull, 8'($urandom), 1'b0);
    do_item(CmdPull, 8'($urandom), 1'b1);
  endtask

  initial begin
    for (int i = 0; i < TblSize; i++) begin
      pfx_tbl[i] = '0;
      sfx_tbl[i] = (i < 256) ? 8'(i) : 8'h00;
      chr_stk[i] = '0;
      g_safe[i] = 0;
    end
    p_lvl = 0; p_acc = 0; p_fill = 0; p_gpos = 0; p_skip = 0;
    p_w = StartWidth; p_lim = 511; p_nf = FirstFree;
    p_prev = 0; p_pchar = 0; p_clr = 0; p_first = 0; p_end = 0;
    p_sum = '0; p_cnt = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_dict_full();
    test_mode_switch();
    test_backpressure();
    test_random();
    test_stream_end();
    in_valid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && answer_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
